[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the lexer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: invariant violated");

// A consequence that must hold in the same cycle as its trigger.
`define ASSERT_IMPLIES(label, clk, rst, trig, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
      else $error("assertion failed: implication violated");

// A consequence that must hold in the cycle after its trigger.
`define ASSERT_NEXT(label, clk, rst, trig, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
      else $error("assertion failed: next-cycle implication violated");

`endif

[hdl/ctl_pkg.sv]
// ----------------------------------------------------------------------------
// ctl_pkg
// Types, codes, character constants and character classes of the lexer.
// ----------------------------------------------------------------------------
package ctl_pkg;

   localparam int LINE_BITS_DEFAULT   = 16;
   localparam int COLUMN_BITS_DEFAULT = 12;

   typedef enum logic [3:0] {
      M_IDLE      = 4'd0,
      M_IDENT     = 4'd1,
      M_NUMBER    = 4'd2,
      M_STR       = 4'd3,
      M_STR_ESC   = 4'd4,
      M_CHR       = 4'd5,
      M_CHR_ESC   = 4'd6,
      M_OP2       = 4'd7,
      M_LINE_CMT  = 4'd8,
      M_BLK_OPEN  = 4'd9,
      M_BLK       = 4'd10,
      M_BLK_STAR  = 4'd11
   } lex_mode_type;

   typedef enum logic [1:0] {
      R_SKIP    = 2'd0,
      R_COMMENT = 2'd1,
      R_START   = 2'd2,
      R_CONT    = 2'd3
   } role_type;

   typedef enum logic [1:0] {
      K_IDENT   = 2'd0,
      K_CONST   = 2'd1,
      K_SPECIAL = 2'd2
   } kind_type;

   localparam logic [7:0] CH_UPPER_A   = 8'd65;
   localparam logic [7:0] CH_UPPER_Z   = 8'd90;
   localparam logic [7:0] CH_LOWER_A   = 8'd97;
   localparam logic [7:0] CH_LOWER_Z   = 8'd122;
   localparam logic [7:0] CH_DIGIT_0   = 8'd48;
   localparam logic [7:0] CH_DIGIT_9   = 8'd57;
   localparam logic [7:0] CH_UNDER     = 8'h5F;
   localparam logic [7:0] CH_QUESTION  = 8'h3F;
   localparam logic [7:0] CH_COLON     = 8'h3A;
   localparam logic [7:0] CH_SEMI      = 8'h3B;
   localparam logic [7:0] CH_HASH      = 8'h23;
   localparam logic [7:0] CH_CARET     = 8'h5E;
   localparam logic [7:0] CH_DOT       = 8'h2E;
   localparam logic [7:0] CH_COMMA     = 8'h2C;
   localparam logic [7:0] CH_LPAREN    = 8'h28;
   localparam logic [7:0] CH_RPAREN    = 8'h29;
   localparam logic [7:0] CH_LBRACKET  = 8'h5B;
   localparam logic [7:0] CH_RBRACKET  = 8'h5D;
   localparam logic [7:0] CH_LBRACE    = 8'h7B;
   localparam logic [7:0] CH_RBRACE    = 8'h7D;
   localparam logic [7:0] CH_PLUS      = 8'h2B;
   localparam logic [7:0] CH_MINUS     = 8'h2D;
   localparam logic [7:0] CH_STAR      = 8'h2A;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_LESS      = 8'h3C;
   localparam logic [7:0] CH_GREATER   = 8'h3E;
   localparam logic [7:0] CH_EQUAL     = 8'h3D;
   localparam logic [7:0] CH_PERCENT   = 8'h25;
   localparam logic [7:0] CH_AMP       = 8'h26;
   localparam logic [7:0] CH_BANG      = 8'h21;
   localparam logic [7:0] CH_PIPE      = 8'h7C;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_SQUOTE    = 8'h27;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;

   // Inputs to the byte classifier.
   typedef struct packed {
      logic [7:0]   char_byte;
      logic         has_next;
      logic [7:0]   next_byte;
      lex_mode_type mode;
   } class_in_type;

   // Label of the byte and the mode for the byte after it.
   typedef struct packed {
      role_type     role;
      kind_type     kind;
      lex_mode_type next_mode;
   } class_out_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
             (c >= CH_LOWER_A && c <= CH_LOWER_Z) || c == CH_UNDER;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= CH_DIGIT_0 && c <= CH_DIGIT_9;
   endfunction

   function automatic logic is_single_special(input logic [7:0] c);
      logic hit;
      case (c) inside
         CH_QUESTION, CH_COLON, CH_SEMI, CH_HASH, CH_CARET, CH_DOT, CH_COMMA,
         CH_LPAREN, CH_RPAREN, CH_LBRACKET, CH_RBRACKET, CH_LBRACE,
         CH_RBRACE: hit = 1'b1;
         default:   hit = 1'b0;
      endcase
      return hit;
   endfunction

   function automatic logic is_op_char(input logic [7:0] c);
      logic hit;
      case (c) inside
         CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_LESS, CH_GREATER, CH_EQUAL,
         CH_PERCENT, CH_AMP, CH_BANG, CH_PIPE: hit = 1'b1;
         default:                              hit = 1'b0;
      endcase
      return hit;
   endfunction

   function automatic logic is_op_second(input logic [7:0] c);
      logic hit;
      case (c) inside
         CH_EQUAL, CH_AMP, CH_GREATER, CH_LESS, CH_PIPE, CH_PLUS,
         CH_MINUS: hit = 1'b1;
         default:  hit = 1'b0;
      endcase
      return hit;
   endfunction

endpackage

[hdl/ctl_if.sv]
// ----------------------------------------------------------------------------
// ctl_if
// Valid/ready channels carrying source bytes in and labeled bytes out.
// ----------------------------------------------------------------------------
interface ctl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       flush;

   modport source (output valid, output text_byte, output flush, input ready);
   modport sink   (input valid, input text_byte, input flush, output ready);
endinterface

interface ctl_rsp_if
   import ctl_pkg::*;
#(
   parameter int LINE_BITS   = LINE_BITS_DEFAULT,
   parameter int COLUMN_BITS = COLUMN_BITS_DEFAULT
);
   logic                   valid;
   logic                   ready;
   logic [7:0]             out_byte;
   logic [1:0]             role;
   logic [1:0]             token_kind;
   logic [LINE_BITS-1:0]   line_no;
   logic [COLUMN_BITS-1:0] column_no;

   modport source (output valid, output out_byte, output role, output token_kind,
                   output line_no, output column_no, input ready);
   modport sink   (input valid, input out_byte, input role, input token_kind,
                   input line_no, input column_no, output ready);
endinterface

[hdl/ctl_classify.sv]
// ----------------------------------------------------------------------------
// ctl_classify
// Labels one held byte from its lexer mode and a one-byte lookahead.
// ----------------------------------------------------------------------------
module ctl_classify
   import ctl_pkg::*;
(
   input  class_in_type  class_in,
   output class_out_type class_out
);

   logic [7:0]    c;
   logic [7:0]    nx;
   class_out_type start_res;

   assign c  = class_in.char_byte;
   assign nx = class_in.next_byte;

   // Classification of a byte seen between tokens.
   always_comb begin
      start_res = '{role: R_SKIP, kind: K_IDENT, next_mode: M_IDLE};
      if (is_single_special(c)) begin
         start_res.role = R_START;
         start_res.kind = K_SPECIAL;
      end else if (c == CH_SLASH && class_in.has_next && nx == CH_SLASH) begin
         start_res.role      = R_COMMENT;
         start_res.next_mode = M_LINE_CMT;
      end else if (c == CH_SLASH && class_in.has_next && nx == CH_STAR) begin
         start_res.role      = R_COMMENT;
         start_res.next_mode = M_BLK_OPEN;
      end else if (is_op_char(c)) begin
         start_res.role = R_START;
         start_res.kind = K_SPECIAL;
         if (class_in.has_next && is_op_second(nx)) begin
            start_res.next_mode = M_OP2;
         end
      end else if (is_letter(c)) begin
         start_res.role      = R_START;
         start_res.next_mode = M_IDENT;
      end else if (is_digit(c)) begin
         start_res.role      = R_START;
         start_res.kind      = K_CONST;
         start_res.next_mode = M_NUMBER;
      end else if (c == CH_DQUOTE) begin
         start_res.role      = R_START;
         start_res.kind      = K_CONST;
         start_res.next_mode = M_STR;
      end else if (c == CH_SQUOTE) begin
         start_res.role      = R_START;
         start_res.kind      = K_CONST;
         start_res.next_mode = M_CHR;
      end
   end

   always_comb begin
      class_out = start_res;
      unique case (class_in.mode)
         M_IDENT: begin
            if (is_letter(c) || is_digit(c)) begin
               class_out = '{role: R_CONT, kind: K_IDENT, next_mode: M_IDENT};
            end
         end
         M_NUMBER: begin
            if (is_digit(c) || c == CH_DOT) begin
               class_out = '{role: R_CONT, kind: K_CONST, next_mode: M_NUMBER};
            end
         end
         M_STR: begin
            class_out = '{role: R_CONT, kind: K_CONST, next_mode: M_STR};
            if (c == CH_BACKSLASH) begin
               class_out.next_mode = M_STR_ESC;
            end else if (c == CH_DQUOTE) begin
               class_out.next_mode = M_IDLE;
            end
         end
         M_CHR: begin
            class_out = '{role: R_CONT, kind: K_CONST, next_mode: M_CHR};
            if (c == CH_BACKSLASH) begin
               class_out.next_mode = M_CHR_ESC;
            end else if (c == CH_SQUOTE) begin
               class_out.next_mode = M_IDLE;
            end
         end
         M_STR_ESC: begin
            class_out = '{role: R_CONT, kind: K_CONST, next_mode: M_STR};
         end
         M_CHR_ESC: begin
            class_out = '{role: R_CONT, kind: K_CONST, next_mode: M_CHR};
         end
         M_OP2: begin
            class_out = '{role: R_CONT, kind: K_SPECIAL, next_mode: M_IDLE};
         end
         M_LINE_CMT: begin
            class_out = '{role: R_COMMENT, kind: K_IDENT, next_mode: M_LINE_CMT};
            if (c == CH_NEWLINE) begin
               class_out.next_mode = M_IDLE;
            end
         end
         M_BLK_OPEN: begin
            class_out = '{role: R_COMMENT, kind: K_IDENT, next_mode: M_BLK};
         end
         M_BLK: begin
            class_out = '{role: R_COMMENT, kind: K_IDENT, next_mode: M_BLK};
            if (c == CH_STAR) begin
               class_out.next_mode = M_BLK_STAR;
            end
         end
         M_BLK_STAR: begin
            class_out = '{role: R_COMMENT, kind: K_IDENT, next_mode: M_BLK};
            if (c == CH_SLASH) begin
               class_out.next_mode = M_IDLE;
            end else if (c == CH_STAR) begin
               class_out.next_mode = M_BLK_STAR;
            end
         end
         default: begin
            class_out = start_res;
         end
      endcase
   end

endmodule

[hdl/c_token_lexer_top.sv]
// ----------------------------------------------------------------------------
// c_token_lexer_top
// Labels a stream of C source bytes with role, token kind, line and column.
// ----------------------------------------------------------------------------
// Labeling: a byte is labeled when the following item is accepted; its result
//   is loaded into the output register on that acceptance.
// Throughput: one item per cycle while the output register is empty or taken,
//   set by the combinational classifier between the held-byte and output registers.
// Reset: synchronous and active high; the held byte is dropped, the mode
//   returns to idle and line and column return to one. No clearing pass.
`include "assert_macros.svh"

module c_token_lexer_top
   import ctl_pkg::*;
#(
   parameter int LINE_BITS   = LINE_BITS_DEFAULT,
   parameter int COLUMN_BITS = COLUMN_BITS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   ctl_req_if.sink    req_chan,
   ctl_rsp_if.source  rsp_chan
);

   localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
   localparam logic [COLUMN_BITS-1:0] COL_ONE  = COLUMN_BITS'(1);

   // The held byte is the one that waits for its lookahead. Its position was
   // captured when it arrived; the current position belongs to the next byte.
   logic                   held_valid_ff, held_valid_in;
   logic [7:0]             held_char_ff, held_char_in;
   logic [LINE_BITS-1:0]   held_line_ff, held_line_in;
   logic [COLUMN_BITS-1:0] held_col_ff, held_col_in;
   logic [LINE_BITS-1:0]   cur_line_ff, cur_line_in;
   logic [COLUMN_BITS-1:0] cur_col_ff, cur_col_in;
   lex_mode_type           mode_ff, mode_in;

   // Output register. It is loaded while it is empty or while its current
   // item is being taken, so the input side never waits on an idle slot.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_byte_ff, rsp_byte_in;
   role_type               rsp_role_ff, rsp_role_in;
   kind_type               rsp_kind_ff, rsp_kind_in;
   logic [LINE_BITS-1:0]   rsp_line_ff, rsp_line_in;
   logic [COLUMN_BITS-1:0] rsp_col_ff, rsp_col_in;

   logic          req_accept;
   class_in_type  class_in;
   class_out_type class_out;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept     = req_chan.valid && req_chan.ready;

   // The newly arriving byte is the lookahead for the held one. A flush item
   // carries no lookahead, so no comment opens and no operator pairs.
   assign class_in = '{char_byte: held_char_ff,
                       has_next:  !req_chan.flush,
                       next_byte: req_chan.text_byte,
                       mode:      mode_ff};

   ctl_classify u_classify (
      .class_in  (class_in),
      .class_out (class_out)
   );

   always_comb begin
      held_valid_in = held_valid_ff;
      held_char_in  = held_char_ff;
      held_line_in  = held_line_ff;
      held_col_in   = held_col_ff;
      cur_line_in   = cur_line_ff;
      cur_col_in    = cur_col_ff;
      mode_in       = mode_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_role_in   = rsp_role_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_line_in   = rsp_line_ff;
      rsp_col_in    = rsp_col_ff;

      if (req_accept) begin
         if (held_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = held_char_ff;
            rsp_role_in  = class_out.role;
            rsp_kind_in  = class_out.kind;
            rsp_line_in  = held_line_ff;
            rsp_col_in   = held_col_ff;
            mode_in      = class_out.next_mode;
         end

         if (req_chan.flush) begin
            // End of input: whatever construct is open is dropped.
            held_valid_in = 1'b0;
            held_char_in  = 8'd0;
            held_line_in  = LINE_ONE;
            held_col_in   = COL_ONE;
            cur_line_in   = LINE_ONE;
            cur_col_in    = COL_ONE;
            mode_in       = M_IDLE;
         end else begin
            held_valid_in = 1'b1;
            held_char_in  = req_chan.text_byte;
            held_line_in  = cur_line_ff;
            held_col_in   = cur_col_ff;
            // A newline sits on its own line; the byte after it opens the next
            // line at column one. Both counters stop at all ones.
            if (req_chan.text_byte == CH_NEWLINE) begin
               if (cur_line_ff != '1) begin
                  cur_line_in = cur_line_ff + LINE_ONE;
               end
               cur_col_in = COL_ONE;
            end else if (cur_col_ff != '1) begin
               cur_col_in = cur_col_ff + COL_ONE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         held_char_ff  <= 8'd0;
         held_line_ff  <= LINE_ONE;
         held_col_ff   <= COL_ONE;
         cur_line_ff   <= LINE_ONE;
         cur_col_ff    <= COL_ONE;
         mode_ff       <= M_IDLE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         held_valid_ff <= held_valid_in;
         held_char_ff  <= held_char_in;
         held_line_ff  <= held_line_in;
         held_col_ff   <= held_col_in;
         cur_line_ff   <= cur_line_in;
         cur_col_ff    <= cur_col_in;
         mode_ff       <= mode_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Result payload needs no reset; it is qualified by rsp_valid_ff.
   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_role_ff <= rsp_role_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_line_ff <= rsp_line_in;
      rsp_col_ff  <= rsp_col_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.out_byte   = rsp_byte_ff;
   assign rsp_chan.role       = rsp_role_ff;
   assign rsp_chan.token_kind = rsp_kind_ff;
   assign rsp_chan.line_no    = rsp_line_ff;
   assign rsp_chan.column_no  = rsp_col_ff;

   // With no byte held the lexer must be between tokens.
   `ASSERT_IMPLIES(a_idle_when_empty, clock, reset, !held_valid_ff, mode_ff == M_IDLE)
   // A flush leaves nothing held.
   `ASSERT_NEXT(a_flush_clears, clock, reset, req_accept && req_chan.flush, !held_valid_ff)
   // Labeling a held byte always yields a result in the output register.
   `ASSERT_NEXT(a_result_loaded, clock, reset, req_accept && held_valid_ff, rsp_valid_ff)
   // Skipped and comment bytes carry no token kind.
   `ASSERT_IMPLIES(a_kind_zero, clock, reset,
      rsp_valid_ff && (rsp_role_ff == R_SKIP || rsp_role_ff == R_COMMENT),
      rsp_kind_ff == K_IDENT)
   // Positions count from one and never wrap to zero.
   `ASSERT_ALWAYS(a_pos_nonzero, clock, reset, cur_line_ff != '0 && cur_col_ff != '0)

endmodule

[test/c_token_lexer_top_tb.sv]
// ----------------------------------------------------------------------------
// c_token_lexer_top_tb
// Self-checking testbench for the C source lexer. A short table of directed
// items is walked first, then random C-like text runs with bursty input and
// a stalling output side. Every labeled item is checked against an in-bench
// lexer or, for some directed rows, a hand-written label.
// ----------------------------------------------------------------------------
module c_token_lexer_top_tb
   import ctl_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_W = LINE_BITS_DEFAULT;
   localparam int COL_W  = COLUMN_BITS_DEFAULT;

   // Run shape.
   localparam int RANDOM_ITEMS    = 1220;
   localparam int HOLD_OFF_AT     = 400;
   localparam int DRAIN_AT        = 800;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int TAIL_CYCLES     = 8;
   // Longest legal quiet stretch is the receiver hold-off plus a sender gap.
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int PRINT_LIMIT     = 40;

   // Character sets used to build random source text.
   localparam string WORD_HEAD    = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
   localparam string WORD_TAIL    = "azAZ_0123456789qx";
   localparam string DIGITS       = "0123456789";
   localparam string NUMBER_TAIL  = "0123456789..";
   localparam string SINGLES      = "?:;#^.,()[]{}";
   localparam string OPERATORS    = "+-*/<>=%&!|";
   localparam string OP_SECONDS   = "=&><|+-";
   localparam string QUOTED_TEXT  = "abz09 _/*+\t";
   localparam string LINE_TEXT    = "ab 9/*\"'\\+";
   localparam string BLOCK_TEXT   = "ab */\n*/x\"";
   localparam string BLANKS       = " \t\n";

   // Receiver stall styles; each runs for a random number of cycles.
   typedef enum logic [1:0] {
      RX_STEADY   = 2'd0,
      RX_LIGHT    = 2'd1,
      RX_PERIODIC = 2'd2,
      RX_HEAVY    = 2'd3
   } rx_style_type;

   // Byte classes seen by the lexer between tokens.
   typedef enum logic [2:0] {
      CC_OTHER    = 3'd0,
      CC_LETTER   = 3'd1,
      CC_DIGIT    = 3'd2,
      CC_SINGLE   = 3'd3,
      CC_OPERATOR = 3'd4,
      CC_DQUOTE   = 3'd5,
      CC_SQUOTE   = 3'd6
   } char_class_type;

   // One labeled byte as it leaves the block.
   typedef struct packed {
      logic [7:0]       text;
      role_type         role;
      kind_type         kind;
      logic [LINE_W-1:0] line;
      logic [COL_W-1:0]  column;
   } label_rec_type;

   // One item offered to the block.
   typedef struct packed {
      logic [7:0] text;
      logic       flush;
   } source_item_type;

   // A directed row: the item, and where it is obvious, the label it causes.
   typedef struct packed {
      logic [7:0]    text;
      logic          flush;
      logic          typed;
      label_rec_type want;
   } stim_row_type;

   localparam label_rec_type NO_LABEL = '{8'h00, R_SKIP, K_IDENT, '0, '0};
   localparam int DIRECTED_ROWS = 30;

   // Directed text. Line one is "x_9", 0xFF, 0x00, "0." and a newline: an
   // identifier running over '_' and a digit, the byte extremes skipped, and
   // a number with a dot. Line two holds a string with an escaped quote, a
   // block comment whose "/*/" must not close it, "<=" paired, and a line
   // comment that takes its newline. Then a flush on an operator byte (no
   // pairing), a flush with nothing held, a flush inside an open string, and
   // a flush on a lone '/' that must not open a comment.
   stim_row_type directed [DIRECTED_ROWS] = '{
      '{"x",          1'b0, 1'b0, NO_LABEL},
      '{CH_UNDER,     1'b0, 1'b1, '{"x", R_START, K_IDENT, 16'd1, 12'd1}},
      '{"9",          1'b0, 1'b0, NO_LABEL},
      '{8'hFF,        1'b0, 1'b0, NO_LABEL},
      '{8'h00,        1'b0, 1'b1, '{8'hFF, R_SKIP, K_IDENT, 16'd1, 12'd4}},
      '{"0",          1'b0, 1'b1, '{8'h00, R_SKIP, K_IDENT, 16'd1, 12'd5}},
      '{CH_DOT,       1'b0, 1'b0, NO_LABEL},
      '{CH_NEWLINE,   1'b0, 1'b0, NO_LABEL},
      '{CH_DQUOTE,    1'b0, 1'b0, NO_LABEL},
      '{CH_BACKSLASH, 1'b0, 1'b0, NO_LABEL},
      '{CH_DQUOTE,    1'b0, 1'b0, NO_LABEL},
      '{CH_DQUOTE,    1'b0, 1'b0, NO_LABEL},
      '{CH_SLASH,     1'b0, 1'b0, NO_LABEL},
      '{CH_STAR,      1'b0, 1'b0, NO_LABEL},
      '{CH_SLASH,     1'b0, 1'b0, NO_LABEL},
      '{CH_STAR,      1'b0, 1'b0, NO_LABEL},
      '{CH_SLASH,     1'b0, 1'b0, NO_LABEL},
      '{CH_LESS,      1'b0, 1'b0, NO_LABEL},
      '{CH_EQUAL,     1'b0, 1'b0, NO_LABEL},
      '{CH_SLASH,     1'b0, 1'b0, NO_LABEL},
      '{CH_SLASH,     1'b0, 1'b0, NO_LABEL},
      '{CH_NEWLINE,   1'b0, 1'b0, NO_LABEL},
      '{CH_MINUS,     1'b0, 1'b0, NO_LABEL},
      '{8'h00,        1'b1, 1'b1, '{CH_MINUS, R_START, K_SPECIAL, 16'd3, 12'd1}},
      '{8'hFF,        1'b1, 1'b0, NO_LABEL},
      '{CH_DQUOTE,    1'b0, 1'b0, NO_LABEL},
      '{"q",          1'b0, 1'b0, NO_LABEL},
      '{8'h00,        1'b1, 1'b1, '{"q", R_CONT, K_CONST, 16'd1, 12'd2}},
      '{CH_SLASH,     1'b0, 1'b0, NO_LABEL},
      '{8'h00,        1'b1, 1'b1, '{CH_SLASH, R_START, K_SPECIAL, 16'd1, 12'd1}}
   };

   logic clock;
   logic reset;
   logic hold_off_req;

   // In-bench lexer state: the byte waiting for its lookahead, its position,
   // the position of the next byte, and the current lexing mode.
   lex_mode_type      lex_state;
   logic              held_ok;
   logic [7:0]        held_text;
   logic [LINE_W-1:0] held_line;
   logic [COL_W-1:0]  held_col;
   logic [LINE_W-1:0] next_line;
   logic [COL_W-1:0]  next_col;

   label_rec_type   pending_labels [$];
   source_item_type text_queue [$];
   int              mismatch_count;
   int              labels_seen;
   int              burst_left;
   int              quiet_cycles;

   ctl_req_if req_bus ();
   ctl_rsp_if #(.LINE_BITS(LINE_W), .COLUMN_BITS(COL_W)) rsp_bus ();

   c_token_lexer_top u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Lexer prediction
   // ------------------------------------------------------------------------

   function automatic char_class_type class_of(input logic [7:0] c);
      if ((c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
          c == CH_UNDER) begin
         return CC_LETTER;
      end
      if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
         return CC_DIGIT;
      end
      case (c)
         CH_QUESTION, CH_COLON, CH_SEMI, CH_HASH, CH_CARET, CH_DOT, CH_COMMA, CH_LPAREN,
         CH_RPAREN, CH_LBRACKET, CH_RBRACKET, CH_LBRACE, CH_RBRACE: return CC_SINGLE;
         CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_LESS, CH_GREATER, CH_EQUAL, CH_PERCENT,
         CH_AMP, CH_BANG, CH_PIPE: return CC_OPERATOR;
         CH_DQUOTE: return CC_DQUOTE;
         CH_SQUOTE: return CC_SQUOTE;
         default: return CC_OTHER;
      endcase
   endfunction

   // True when c can be the second half of a two-character operator.
   function automatic logic joins_operator(input logic [7:0] c);
      return c == CH_EQUAL || c == CH_AMP || c == CH_GREATER || c == CH_LESS ||
             c == CH_PIPE || c == CH_PLUS || c == CH_MINUS;
   endfunction

   task automatic clear_lexer();
      lex_state = M_IDLE;
      held_ok   = 1'b0;
      held_text = '0;
      held_line = LINE_W'(1);
      held_col  = COL_W'(1);
      next_line = LINE_W'(1);
      next_col  = COL_W'(1);
   endtask

   // Labels the held byte c given the lookahead nx (valid when has_nx), and
   // moves lex_state on to the mode for the byte after it.
   task automatic classify_held(input logic [7:0] c, input logic has_nx,
                                input logic [7:0] nx, output role_type r,
                                output kind_type k);
      char_class_type cls;
      logic           settled;
      cls     = class_of(c);
      settled = 1'b1;
      r       = R_SKIP;
      k       = K_IDENT;
      case (lex_state)
         M_IDENT: begin
            if (cls == CC_LETTER || cls == CC_DIGIT) begin
               r = R_CONT;
               k = K_IDENT;
            end else begin
               settled = 1'b0;
            end
         end
         M_NUMBER: begin
            if (cls == CC_DIGIT || c == CH_DOT) begin
               r = R_CONT;
               k = K_CONST;
            end else begin
               settled = 1'b0;
            end
         end
         M_STR, M_CHR: begin
            r = R_CONT;
            k = K_CONST;
            if (c == CH_BACKSLASH) begin
               lex_state = (lex_state == M_STR) ? M_STR_ESC : M_CHR_ESC;
            end else if ((lex_state == M_STR && c == CH_DQUOTE) ||
                         (lex_state == M_CHR && c == CH_SQUOTE)) begin
               lex_state = M_IDLE;
            end
         end
         M_STR_ESC, M_CHR_ESC: begin
            // The escaped byte belongs to the literal whatever it is.
            r = R_CONT;
            k = K_CONST;
            lex_state = (lex_state == M_STR_ESC) ? M_STR : M_CHR;
         end
         M_OP2: begin
            r = R_CONT;
            k = K_SPECIAL;
            lex_state = M_IDLE;
         end
         M_LINE_CMT: begin
            r = R_COMMENT;
            if (c == CH_NEWLINE) lex_state = M_IDLE;
         end
         M_BLK_OPEN: begin
            r = R_COMMENT;
            lex_state = M_BLK;
         end
         M_BLK: begin
            r = R_COMMENT;
            if (c == CH_STAR) lex_state = M_BLK_STAR;
         end
         M_BLK_STAR: begin
            r = R_COMMENT;
            if (c == CH_SLASH) begin
               lex_state = M_IDLE;
            end else if (c != CH_STAR) begin
               lex_state = M_BLK;
            end
         end
         default: settled = 1'b0;
      endcase

      // Between tokens: the byte starts something new or is skipped.
      if (!settled) begin
         lex_state = M_IDLE;
         r = R_START;
         k = K_SPECIAL;
         if (cls == CC_SINGLE) begin
            // one-byte special
         end else if (c == CH_SLASH && has_nx && nx == CH_SLASH) begin
            r = R_COMMENT;
            k = K_IDENT;
            lex_state = M_LINE_CMT;
         end else if (c == CH_SLASH && has_nx && nx == CH_STAR) begin
            r = R_COMMENT;
            k = K_IDENT;
            lex_state = M_BLK_OPEN;
         end else if (cls == CC_OPERATOR) begin
            if (has_nx && joins_operator(nx)) lex_state = M_OP2;
         end else if (cls == CC_LETTER) begin
            k = K_IDENT;
            lex_state = M_IDENT;
         end else if (cls == CC_DIGIT) begin
            k = K_CONST;
            lex_state = M_NUMBER;
         end else if (cls == CC_DQUOTE) begin
            k = K_CONST;
            lex_state = M_STR;
         end else if (cls == CC_SQUOTE) begin
            k = K_CONST;
            lex_state = M_CHR;
         end else begin
            r = R_SKIP;
            k = K_IDENT;
         end
      end
   endtask

   // Takes one accepted item. The held byte, if any, is labeled with the new
   // byte as lookahead (none on a flush); the new byte then becomes held.
   task automatic advance_lexer(input logic [7:0] text, input logic flush,
                                output logic labeled, output label_rec_type lab);
      role_type r;
      kind_type k;
      labeled = held_ok;
      lab     = NO_LABEL;
      if (held_ok) begin
         classify_held(held_text, !flush, text, r, k);
         lab = '{held_text, r, k, held_line, held_col};
      end
      if (flush) begin
         clear_lexer();
      end else begin
         held_ok   = 1'b1;
         held_text = text;
         held_line = next_line;
         held_col  = next_col;
         if (text == CH_NEWLINE) begin
            if (next_line != '1) next_line++;
            next_col = COL_W'(1);
         end else if (next_col != '1) begin
            next_col++;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Input side
   // ------------------------------------------------------------------------

   // After each accepted item the sender either carries on in its burst or
   // drops valid for a random gap. Bursts are mostly short, sometimes long
   // enough to run for hundreds of items without a gap.
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_bus.valid     <= 1'b0;
            req_bus.text_byte <= 8'($urandom);
            req_bus.flush     <= 1'($urandom);
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 20);
      end
   endtask

   // Offers one item and holds it until the block takes it. On acceptance
   // the label it releases goes into the pending list; a directed row may
   // supply its own hand-written label instead of the predicted one.
   task automatic offer_item(input logic [7:0] text, input logic flush,
                             input logic typed, input label_rec_type want);
      logic          labeled;
      label_rec_type lab;
      req_bus.valid     <= 1'b1;
      req_bus.text_byte <= text;
      req_bus.flush     <= flush;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      advance_lexer(text, flush, labeled, lab);
      if (labeled) pending_labels.push_back(typed ? want : lab);
      pace_sender();
   endtask

   // Stops offering and waits until every label owed so far has come out.
   task automatic drain_labels();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_labels.size() != 0);
   endtask

   function automatic logic [7:0] pick_from(input string set);
      return set[$urandom_range(0, set.len() - 1)];
   endfunction

   task automatic queue_byte(input logic [7:0] b);
      text_queue.push_back('{b, 1'b0});
   endtask

   // Appends one random fragment of C-like text. Most fragments are well
   // formed so that literals, comments and operator pairs are reached; some
   // literals and comments are left open, and raw bytes and flushes are
   // mixed in as noise.
   task automatic compose_fragment();
      int         roll;
      logic [7:0] quote;
      roll = $urandom_range(0, 99);
      if (roll < 18) begin
         queue_byte(pick_from(WORD_HEAD));
         repeat ($urandom_range(0, 6)) queue_byte(pick_from(WORD_TAIL));
      end else if (roll < 28) begin
         queue_byte(pick_from(DIGITS));
         repeat ($urandom_range(0, 5)) queue_byte(pick_from(NUMBER_TAIL));
      end else if (roll < 42) begin
         quote = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
         queue_byte(quote);
         repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(0, 4) == 0) begin
               queue_byte(CH_BACKSLASH);
               queue_byte(8'($urandom));
            end else begin
               queue_byte(pick_from(QUOTED_TEXT));
            end
         end
         if ($urandom_range(0, 9) != 0) queue_byte(quote);
      end else if (roll < 56) begin
         queue_byte(pick_from(OPERATORS));
         if ($urandom_range(0, 1) == 0) queue_byte(pick_from(OP_SECONDS));
      end else if (roll < 66) begin
         queue_byte(pick_from(SINGLES));
      end else if (roll < 71) begin
         queue_byte(CH_SLASH);
         queue_byte(CH_SLASH);
         repeat ($urandom_range(0, 8)) queue_byte(pick_from(LINE_TEXT));
         queue_byte(CH_NEWLINE);
      end else if (roll < 76) begin
         queue_byte(CH_SLASH);
         queue_byte(CH_STAR);
         repeat ($urandom_range(0, 8)) queue_byte(pick_from(BLOCK_TEXT));
         if ($urandom_range(0, 6) != 0) begin
            queue_byte(CH_STAR);
            queue_byte(CH_SLASH);
         end
      end else if (roll < 90) begin
         repeat ($urandom_range(1, 3)) queue_byte(pick_from(BLANKS));
      end else if (roll < 97) begin
         repeat ($urandom_range(1, 3)) queue_byte(8'($urandom));
      end else begin
         text_queue.push_back('{8'($urandom), 1'b1});
      end
   endtask

   // ------------------------------------------------------------------------
   // Output side
   // ------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input longint unsigned want,
                                  input longint unsigned got);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("[%0t] label %0d: %s expected 0x%0h got 0x%0h",
                  $realtime, labels_seen, what, want, got);
      end
      mismatch_count++;
   endtask

   // Compares one accepted label with the oldest pending one, field by field.
   task automatic check_label();
      label_rec_type want;
      if (pending_labels.size() == 0) begin
         report_mismatch("label with none pending, out_byte", 0, rsp_bus.out_byte);
      end else begin
         want = pending_labels.pop_front();
         if (rsp_bus.out_byte !== want.text)
            report_mismatch("out_byte", want.text, rsp_bus.out_byte);
         if (rsp_bus.role !== want.role)
            report_mismatch("role", want.role, rsp_bus.role);
         if (rsp_bus.token_kind !== want.kind)
            report_mismatch("token_kind", want.kind, rsp_bus.token_kind);
         if (rsp_bus.line_no !== want.line)
            report_mismatch("line_no", want.line, rsp_bus.line_no);
         if (rsp_bus.column_no !== want.column)
            report_mismatch("column_no", want.column, rsp_bus.column_no);
      end
      labels_seen++;
   endtask

   // Values sampled at the clock edge are the ones the block saw there,
   // since every testbench drive is a nonblocking update at the edge.
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) check_label();
   end

   // The receiver switches between stall styles of random length. When the
   // main flow asks for it, it refuses everything for a long stretch so the
   // block fills and pushes back on its input.
   initial begin : receiver
      rx_style_type style;
      int           style_left;
      int           beat;
      rsp_bus.ready = 1'b0;
      style         = RX_STEADY;
      style_left    = 0;
      beat          = 0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end else begin
            if (style_left == 0) begin
               style      = rx_style_type'($urandom_range(0, 3));
               style_left = $urandom_range(50, 300);
            end
            style_left--;
            beat++;
            case (style)
               RX_STEADY:   rsp_bus.ready <= 1'b1;
               RX_LIGHT:    rsp_bus.ready <= ($urandom_range(0, 9) < 7);
               RX_PERIODIC: rsp_bus.ready <= ((beat % 5) < 2);
               default:     rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // A run that stops moving in both directions for too long is hung.
   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("** c_token_lexer_top: FAILED **");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Main flow
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int              row;
      int              sent;
      source_item_type item;

      // Every input is known from time zero; reset is held, then released.
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.text_byte = '0;
      req_bus.flush     = 1'b0;
      hold_off_req      = 1'b0;
      mismatch_count    = 0;
      labels_seen       = 0;
      burst_left        = 0;
      quiet_cycles      = 0;
      clear_lexer();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed table. It ends with a flush, so the lexer is back at reset.
      for (row = 0; row < DIRECTED_ROWS; row++) begin
         offer_item(directed[row].text, directed[row].flush, directed[row].typed,
                    directed[row].want);
      end

      // Random text. Partway through, the receiver holds off while the
      // sender keeps offering; later the sender stops until all labels owed
      // so far have come out, with a byte still held inside the block.
      for (sent = 0; sent < RANDOM_ITEMS; sent++) begin
         if (text_queue.size() == 0) compose_fragment();
         item = text_queue.pop_front();
         offer_item(item.text, item.flush, 1'b0, NO_LABEL);
         if (sent == HOLD_OFF_AT) hold_off_req = 1'b1;
         if (sent == DRAIN_AT) drain_labels();
      end

      // A closing flush releases the last held byte.
      offer_item(8'h00, 1'b1, 1'b0, NO_LABEL);
      drain_labels();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("** c_token_lexer_top: PASSED **");
      end else begin
         $display("** c_token_lexer_top: FAILED **");
      end
      $finish;
   end

endmodule
